// ----- rtl/smoothed_cubic_volume_gain_macros.svh -----
// ----------------------------------------------------------------------------
// smoothed cubic volume gain assertion macros
// shared helpers for the concurrent checks of the volume gain block
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_CUBIC_VOLUME_GAIN_MACROS_SVH
`define SMOOTHED_CUBIC_VOLUME_GAIN_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SCVG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SCVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/scvg_pkg.sv -----
// ----------------------------------------------------------------------------
// scvg_pkg
// widths, gain table and shared types of the smoothed volume gain block
// ----------------------------------------------------------------------------
`default_nettype none

package scvg_pkg;

    localparam int GAIN_FRAC_BITS = 23;
    localparam int SAMPLE_BITS    = 32;
    localparam int OUT_BITS       = SAMPLE_BITS + 1;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 2;
    localparam int VOL_W          = 8;
    localparam int ALPHA_W        = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int IN_TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int MUL_A_W        = SAMPLE_BITS;
    localparam int MUL_B_W        = GAIN_W;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    localparam int STEP_PROD_W    = ALPHA_W + GAIN_W;
    localparam int VOL_MAX        = 200;

    localparam longint unsigned GAIN_ONE  = 64'd1 << GAIN_FRAC_BITS;
    localparam longint unsigned SNAP_RAW  = (GAIN_ONE + 64'd50000) / 64'd100000;
    localparam longint unsigned SNAP_THR  = (SNAP_RAW > 64'd0) ? SNAP_RAW : 64'd1;
    localparam longint unsigned GAIN_MAX  = GAIN_ONE << 1;

    localparam logic [GAIN_W-1:0]    SNAP_THRESHOLD = GAIN_W'(SNAP_THR);
    localparam logic [GAIN_W-1:0]    GAIN_LIMIT     = GAIN_W'(GAIN_MAX);
    localparam logic [VOL_W-1:0]     VOL_RESET      = VOL_W'(100);
    localparam logic [VOL_W-1:0]     VOL_SAT        = VOL_W'(VOL_MAX);
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET    = ALPHA_W'(99);

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = CFG_IDX_W'(1);

    typedef logic [GAIN_W-1:0] t_gain_table [0:VOL_MAX];

    // target gain per volume step, worked out at elaboration
    function automatic t_gain_table build_target_table();
        t_gain_table     tbl;
        longint unsigned v;
        for (int i = 0; i <= VOL_MAX; i++) begin
            v = longint'(i);
            if (i == 0) begin
                tbl[i] = '0;
            end else if (i <= 100) begin
                tbl[i] = GAIN_W'(((v * v * v << GAIN_FRAC_BITS) + 64'd500000) / 64'd1000000);
            end else begin
                tbl[i] = GAIN_W'(GAIN_ONE
                         + ((((v - 64'd100) << GAIN_FRAC_BITS) + 64'd50) / 64'd100));
            end
        end
        return tbl;
    endfunction

    localparam t_gain_table TARGET_TABLE = build_target_table();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TGT,
        ST_MULA,
        ST_STEP,
        ST_MULS,
        ST_RES
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_gain_ctl;

    typedef struct packed {
        logic              started;
        logic [GAIN_W-1:0] gain;
        logic [GAIN_W-1:0] diff;
    } t_gain_sts;

endpackage

`default_nettype wire

// ----- rtl/scvg_mul.sv -----
// ----------------------------------------------------------------------------
// scvg_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
`default_nettype none

module scvg_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [scvg_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [scvg_pkg::MUL_B_W-1:0] i_b,
    output logic      [scvg_pkg::PROD_W-1:0]  o_prod
);

    logic [scvg_pkg::PROD_W-1:0] r_prod;
    logic [scvg_pkg::PROD_W-1:0] n_prod;

    assign n_prod = scvg_pkg::PROD_W'(i_a) * scvg_pkg::PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- rtl/scvg_gain.sv -----
// ----------------------------------------------------------------------------
// scvg_gain
// kept gain, target lookup and one-pole step toward the target
// ----------------------------------------------------------------------------
`default_nettype none

module scvg_gain (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire scvg_pkg::t_gain_ctl            i_ctl,
    input  wire logic [scvg_pkg::VOL_W-1:0]     i_volume,
    input  wire logic [scvg_pkg::PROD_W-1:0]    i_prod,
    output scvg_pkg::t_gain_sts                 o_sts
);

    logic                        r_started;
    logic [scvg_pkg::GAIN_W-1:0] r_gain;
    logic [scvg_pkg::GAIN_W-1:0] r_tgt;
    logic [scvg_pkg::GAIN_W-1:0] r_diff;
    logic                        r_up;

    logic                        n_started;
    logic [scvg_pkg::GAIN_W-1:0] n_gain;
    logic [scvg_pkg::GAIN_W-1:0] n_tgt;
    logic [scvg_pkg::GAIN_W-1:0] n_diff;
    logic                        n_up;

    logic [scvg_pkg::VOL_W-1:0]         w_vol;
    logic [scvg_pkg::GAIN_W-1:0]        w_tgt;
    logic [scvg_pkg::GAIN_W-1:0]        w_gain0;
    logic [scvg_pkg::STEP_PROD_W:0]     w_step_sum;
    logic [scvg_pkg::GAIN_W:0]          w_step_raw;
    logic [scvg_pkg::GAIN_W-1:0]        w_step;

    assign w_vol   = (i_volume > scvg_pkg::VOL_SAT) ? scvg_pkg::VOL_SAT : i_volume;
    assign w_tgt   = scvg_pkg::TARGET_TABLE[w_vol];
    // first frame after reset starts right at the target
    assign w_gain0 = r_started ? r_gain : w_tgt;

    // round alpha * diff to the nearest step, then clamp to [1, diff]
    assign w_step_sum = {1'b0, i_prod[scvg_pkg::STEP_PROD_W-1:0]}
                        + (scvg_pkg::STEP_PROD_W + 1)'(32768);
    assign w_step_raw = w_step_sum[scvg_pkg::STEP_PROD_W:scvg_pkg::ALPHA_W];

    always_comb begin
        if (w_step_raw == '0) begin
            w_step = scvg_pkg::GAIN_W'(1);
        end else if (w_step_raw > {1'b0, r_diff}) begin
            w_step = r_diff;
        end else begin
            w_step = w_step_raw[scvg_pkg::GAIN_W-1:0];
        end
    end

    always_comb begin
        n_started = r_started;
        n_gain    = r_gain;
        n_tgt     = r_tgt;
        n_diff    = r_diff;
        n_up      = r_up;
        if (i_ctl.load) begin
            n_started = 1'b1;
            n_gain    = w_gain0;
            n_tgt     = w_tgt;
            n_up      = (w_tgt >= w_gain0);
            n_diff    = (w_tgt >= w_gain0) ? (w_tgt - w_gain0) : (w_gain0 - w_tgt);
        end else if (i_ctl.step) begin
            if (r_diff < scvg_pkg::SNAP_THRESHOLD) begin
                n_gain = r_tgt;
            end else if (r_up) begin
                n_gain = r_gain + w_step;
            end else begin
                n_gain = r_gain - w_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_gain    <= '0;
        end else begin
            r_started <= n_started;
            r_gain    <= n_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt  <= n_tgt;
        r_diff <= n_diff;
        r_up   <= n_up;
    end

    assign o_sts.started = r_started;
    assign o_sts.gain    = r_gain;
    assign o_sts.diff    = r_diff;

endmodule

`default_nettype wire

// ----- rtl/smoothed_cubic_volume_gain.sv -----
// states per beat: ST_TGT, ST_MULA, ST_STEP, ST_MULS, ST_RES on a frame start,
//   ST_MULS, ST_RES otherwise; no new beat is taken until the FSM is back in ST_IDLE;
//   the single shared 32x25 multiplier serves the gain step and the sample product
// the result sits in an output register, so a new beat is taken while it waits
// reset (synchronous, active low): volume 100, alpha 99, gain cleared, first beat
//   after reset loads the target gain directly
// ----------------------------------------------------------------------------
// smoothed_cubic_volume_gain
// pcm volume scaling with a frame-rate one-pole smoothed cubic gain
// ----------------------------------------------------------------------------
`default_nettype none

`include "smoothed_cubic_volume_gain_macros.svh"

module smoothed_cubic_volume_gain (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write port
    input  wire logic                                i_cfg_we,
    input  wire logic [scvg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [scvg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [scvg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] pcm_sample
    input  wire logic                                s_axis_tuser,  // [0] frame_start
    // output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [scvg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [32:0] scaled_sample
);

    scvg_pkg::t_state r_state;
    scvg_pkg::t_state n_state;

    logic [scvg_pkg::VOL_W-1:0]       r_volume;
    logic [scvg_pkg::ALPHA_W-1:0]     r_alpha;
    logic [scvg_pkg::SAMPLE_BITS-1:0] r_sample;
    logic                             r_out_valid;
    logic [scvg_pkg::OUT_BITS-1:0]    r_out_data;
    logic [scvg_pkg::OUT_BITS-1:0]    n_out_data;

    logic                             w_in_beat;
    logic                             w_out_load;
    logic                             w_mul_en;
    logic [scvg_pkg::MUL_A_W-1:0]     w_mul_a;
    logic [scvg_pkg::MUL_B_W-1:0]     w_mul_b;
    logic [scvg_pkg::PROD_W-1:0]      w_prod;
    logic [scvg_pkg::SAMPLE_BITS-1:0] w_mag;
    logic [scvg_pkg::PROD_W:0]        w_prod_rnd;
    logic [scvg_pkg::OUT_BITS-1:0]    w_q;
    scvg_pkg::t_gain_ctl              w_gain_ctl;
    scvg_pkg::t_gain_sts              w_gain_sts;

    assign w_in_beat = s_axis_tvalid && s_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= scvg_pkg::VOL_RESET;
            r_alpha  <= scvg_pkg::ALPHA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scvg_pkg::REG_VOLUME: r_volume <= i_cfg_data[scvg_pkg::VOL_W-1:0];
                scvg_pkg::REG_ALPHA:  r_alpha  <= i_cfg_data[scvg_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_sample <= s_axis_tdata[scvg_pkg::SAMPLE_BITS-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scvg_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    if (s_axis_tuser || !w_gain_sts.started) begin
                        n_state = scvg_pkg::ST_TGT;
                    end else begin
                        n_state = scvg_pkg::ST_MULS;
                    end
                end
            end
            scvg_pkg::ST_TGT:  n_state = scvg_pkg::ST_MULA;
            scvg_pkg::ST_MULA: n_state = scvg_pkg::ST_STEP;
            scvg_pkg::ST_STEP: n_state = scvg_pkg::ST_MULS;
            scvg_pkg::ST_MULS: n_state = scvg_pkg::ST_RES;
            scvg_pkg::ST_RES: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = scvg_pkg::ST_IDLE;
                end
            end
            default: n_state = scvg_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready   = 1'b0;
        w_gain_ctl.load = 1'b0;
        w_gain_ctl.step = 1'b0;
        w_mul_en        = 1'b0;
        w_mul_a         = scvg_pkg::MUL_A_W'(r_alpha);
        w_mul_b         = w_gain_sts.diff;
        w_out_load      = 1'b0;
        case (r_state)
            scvg_pkg::ST_IDLE: s_axis_tready = 1'b1;
            scvg_pkg::ST_TGT:  w_gain_ctl.load = 1'b1;
            scvg_pkg::ST_MULA: w_mul_en = 1'b1;
            scvg_pkg::ST_STEP: w_gain_ctl.step = 1'b1;
            scvg_pkg::ST_MULS: begin
                w_mul_en = 1'b1;
                w_mul_a  = w_mag;
                w_mul_b  = w_gain_sts.gain;
            end
            scvg_pkg::ST_RES:  w_out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scvg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sample magnitude; the most negative sample maps onto itself as unsigned
    assign w_mag = r_sample[scvg_pkg::SAMPLE_BITS-1]
                   ? (~r_sample + scvg_pkg::SAMPLE_BITS'(1)) : r_sample;

    scvg_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    scvg_gain u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_gain_ctl),
        .i_volume (r_volume),
        .i_prod   (w_prod),
        .o_sts    (w_gain_sts)
    );

    // floor of the signed product: negative side rounds the magnitude up
    assign w_prod_rnd = {1'b0, w_prod}
                        + (r_sample[scvg_pkg::SAMPLE_BITS-1]
                           ? (scvg_pkg::PROD_W + 1)'(scvg_pkg::GAIN_ONE - 64'd1)
                           : '0);
    assign w_q = w_prod_rnd[scvg_pkg::GAIN_FRAC_BITS +: scvg_pkg::OUT_BITS];
    assign n_out_data = r_sample[scvg_pkg::SAMPLE_BITS-1]
                        ? (scvg_pkg::OUT_BITS'(0) - w_q) : w_q;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = scvg_pkg::OUT_TDATA_W'(r_out_data);

    `SCVG_ASSERT_NEXT(a_busy_after_beat, w_in_beat, !s_axis_tready, "input accepted while busy")
    `SCVG_ASSERT_NEXT(a_result_lands, w_out_load, m_axis_tvalid, "result missed output register")
    `SCVG_ASSERT_SAME(a_gain_bounded, 1'b1, w_gain_sts.gain <= scvg_pkg::GAIN_LIMIT, "gain above 2.0")

endmodule

`default_nettype wire
